// File: src/xcems_pkg.sv
// shared types, codes and register helpers for the ems register block
package xcems_pkg;

   // request codes
   localparam logic [1:0] CMD_IO_WR = 2'd0;
   localparam logic [1:0] CMD_IO_RD = 2'd1;
   localparam logic [1:0] CMD_XLATE = 2'd2;

   // i/o ports
   localparam logic [15:0] PORT_INDEX   = 16'h0022;
   localparam logic [15:0] PORT_DATA    = 16'h0023;
   localparam logic [15:0] PORT_EXTRA0  = 16'h0072;
   localparam logic [15:0] PORT_EXTRA1  = 16'h007E;
   localparam logic [15:0] PORT_EXTRA2  = 16'h007F;
   localparam logic [13:0] PAGE_PORT_BASE = 14'h0208;

   // configuration register indexes
   localparam logic [7:0] REG_CTL0     = 8'h40;
   localparam logic [7:0] REG_CTL1     = 8'h41;
   localparam logic [7:0] REG_CTL2     = 8'h42;
   localparam logic [7:0] REG_CTL3     = 8'h43;
   localparam logic [7:0] REG_NMI0     = 8'h44;
   localparam logic [7:0] REG_NMI1     = 8'h45;
   localparam logic [7:0] REG_NMI2     = 8'h46;
   localparam logic [7:0] REG_NMI3     = 8'h47;
   localparam logic [7:0] REG_CTL8     = 8'h48;
   localparam logic [7:0] REG_LAST_LOW = 8'h49;
   localparam logic [7:0] REG_NMI_CTL  = 8'h4B;
   localparam logic [7:0] REG_EMS_BASE = 8'h4C;

   localparam int CFG_DEPTH     = 12;
   localparam int EXTRA_DEPTH   = 3;
   localparam logic [3:0] SLOT_CTL1     = 4'd1;
   localparam logic [3:0] SLOT_NMI_CTL  = 4'd10;
   localparam logic [3:0] SLOT_EMS_BASE = 4'd11;

   localparam int NUM_PAGES_DEF = 4;
   localparam logic [12:0] MEM_SIZE_RESET = 13'd640;

   // window block numbers are in 16K units: 0xC0000 and 0xA0000, and the xor 0xC000
   localparam logic [6:0] WIN_BLOCK_BASE  = 7'h30;
   localparam logic [6:0] WIN_BLOCK_FLIP  = 7'h03;
   localparam logic [7:0] PHYS_BLOCK_BASE = 8'h28;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] io_port;
      logic [7:0]  write_data;
      logic [19:0] mem_addr;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [31:0] nmi_vector;
      logic        nmi_vector_on;
      logic        soft_reset;
   } rf_rsp_type;

   typedef struct packed {
      logic        ems_hit;
      logic [1:0]  hit_page;
      logic [21:0] phys_addr;
      logic        in_range;
   } xl_rsp_type;

   function automatic logic cfg_slot_ok(input logic [7:0] idx);
      cfg_slot_ok = (idx >= REG_CTL0 && idx <= REG_LAST_LOW) ||
                    idx == REG_NMI_CTL || idx == REG_EMS_BASE;
   endfunction

   function automatic logic [3:0] cfg_slot(input logic [7:0] idx);
      logic [7:0] diff;
      diff = idx - REG_CTL0;
      if (idx == REG_NMI_CTL) begin
         cfg_slot = SLOT_NMI_CTL;
      end else if (idx == REG_EMS_BASE) begin
         cfg_slot = SLOT_EMS_BASE;
      end else begin
         cfg_slot = diff[3:0];
      end
   endfunction

   function automatic logic [7:0] cfg_mask(input logic [7:0] idx);
      case (idx)
         REG_CTL0: cfg_mask = 8'hC7;
         REG_CTL1: cfg_mask = 8'hED;
         REG_CTL2: cfg_mask = 8'h01;
         default:  cfg_mask = 8'hFF;
      endcase
   endfunction

   function automatic logic [7:0] cfg_reset(input logic [3:0] slot);
      case (slot)
         4'(REG_CTL0 - REG_CTL0): cfg_reset = 8'h01;
         4'(REG_CTL3 - REG_CTL0): cfg_reset = 8'h30;
         4'(REG_CTL8 - REG_CTL0): cfg_reset = 8'h01;
         default:                 cfg_reset = 8'h00;
      endcase
   endfunction

endpackage

// File: src/xt_chipset_ems_register_block.sv
// top level: request register, register file, translation and result register
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid, req_stall | cmd, io_port, write_data, mem_addr
//  rsp     | out       | rsp_valid, rsp_stall | read_data .. soft_reset
//  csr     | in        | csr_valid, csr_ready | mem_size_kb in csr_data
//
// one request per cycle unless rsp stalls; a request is held in the request register, then its
// result in the result register, where it is valid; the path between is the page
// window compares and the register file decode.
// reset is synchronous; registers come up as after a soft reset, nmi vector zero,
// mem size 640K. a stall on rsp holds the result and backs up into the request
// register; req_stall rises only while that register holds a request that cannot move.
module xt_chipset_ems_register_block
   import xcems_pkg::*;
#(
   parameter int NUM_PAGES = NUM_PAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_io_port,
   input  logic [7:0]  req_write_data,
   input  logic [19:0] req_mem_addr,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_ems_hit,
   output logic [1:0]  rsp_hit_page,
   output logic [21:0] rsp_phys_addr,
   output logic        rsp_in_range,
   output logic [31:0] rsp_nmi_vector,
   output logic        rsp_nmi_vector_on,
   output logic        rsp_soft_reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [12:0] csr_data
);

   logic                      in_valid_ff;
   req_type                   in_req_ff;
   logic                      rsp_valid_ff;
   rf_rsp_type                rf_rsp_ff;
   xl_rsp_type                xl_rsp_ff;
   logic [12:0]               mem_size_ff;

   logic                      advance;
   rf_rsp_type                rf_rsp;
   xl_rsp_type                xl_rsp;
   logic [3:0]                win_base;
   logic [NUM_PAGES-1:0][7:0] page_regs;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;

   xcems_regfile #(
      .NUM_PAGES(NUM_PAGES)
   ) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .go        (advance),
      .req       (in_req_ff),
      .rsp       (rf_rsp),
      .win_base  (win_base),
      .page_regs (page_regs)
   );

   xcems_xlate #(
      .NUM_PAGES(NUM_PAGES)
   ) u_xlate (
      .req         (in_req_ff),
      .win_base    (win_base),
      .page_regs   (page_regs),
      .mem_size_kb (mem_size_ff),
      .rsp         (xl_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mem_size_ff  <= MEM_SIZE_RESET;
      end else begin
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            mem_size_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_req_ff.cmd        <= req_cmd;
         in_req_ff.io_port    <= req_io_port;
         in_req_ff.write_data <= req_write_data;
         in_req_ff.mem_addr   <= req_mem_addr;
      end
      if (advance) begin
         rf_rsp_ff <= rf_rsp;
         xl_rsp_ff <= xl_rsp;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rf_rsp_ff.read_data;
   assign rsp_ems_hit       = xl_rsp_ff.ems_hit;
   assign rsp_hit_page      = xl_rsp_ff.hit_page;
   assign rsp_phys_addr     = xl_rsp_ff.phys_addr;
   assign rsp_in_range      = xl_rsp_ff.in_range;
   assign rsp_nmi_vector    = rf_rsp_ff.nmi_vector;
   assign rsp_nmi_vector_on = rf_rsp_ff.nmi_vector_on;
   assign rsp_soft_reset    = rf_rsp_ff.soft_reset;

`ifndef NO_ASSERTIONS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff)
      else $error("request stalled with room downstream");

   a_range_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_in_range |-> rsp_ems_hit)
      else $error("in range flagged without a window hit");

   a_srst_clears_nmi_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_soft_reset |-> !rsp_nmi_vector_on)
      else $error("soft reset left the nmi vector enabled");

   a_xlate_no_read: assert property (@(posedge clock) disable iff (reset)
      advance && in_req_ff.cmd == CMD_XLATE |=> rsp_read_data == 8'h00 && !rsp_soft_reset)
      else $error("translate request returned read data or soft reset");
`endif

endmodule

// File: src/xcems_regfile.sv
// configuration, extra, page and nmi vector registers with the i/o decode
module xcems_regfile
   import xcems_pkg::*;
#(
   parameter int NUM_PAGES = NUM_PAGES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      go,
   input  req_type                   req,
   output rf_rsp_type                rsp,
   output logic [3:0]                win_base,
   output logic [NUM_PAGES-1:0][7:0] page_regs
);

   localparam int PAGE_IDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

   logic [7:0]                index_ff, index_in;
   logic                      armed_ff, armed_in;
   logic [7:0]                cfg_ff [0:CFG_DEPTH-1];
   logic [7:0]                cfg_in [0:CFG_DEPTH-1];
   logic [7:0]                extra_ff [0:EXTRA_DEPTH-1];
   logic [7:0]                extra_in [0:EXTRA_DEPTH-1];
   logic [NUM_PAGES-1:0][7:0] page_ff, page_in;
   logic [31:0]               nmi_vec_ff, nmi_vec_in;
   logic                      nmi_en_ff, nmi_en_in;

   logic                  slot_ok;
   logic [3:0]            slot;
   logic                  page_port;
   logic [PAGE_IDX_W-1:0] page_idx;
   logic [7:0]            wr_val;
   logic [7:0]            rd_data;
   logic                  srst;

   assign slot_ok  = cfg_slot_ok(index_ff);
   assign slot     = cfg_slot(index_ff);
   assign page_idx = req.io_port[13+PAGE_IDX_W:14];
   assign page_port = (req.io_port[13:0] ==
                       PAGE_PORT_BASE + {6'd0, cfg_ff[SLOT_EMS_BASE][7:4], 4'd0}) &&
                      ({1'b0, req.io_port[15:14]} < 3'(NUM_PAGES));
   assign wr_val = req.write_data & cfg_mask(index_ff);

   always_comb begin
      index_in   = index_ff;
      armed_in   = armed_ff;
      cfg_in     = cfg_ff;
      extra_in   = extra_ff;
      page_in    = page_ff;
      nmi_vec_in = nmi_vec_ff;
      nmi_en_in  = nmi_en_ff;
      rd_data    = 8'h00;
      srst       = 1'b0;
      case (req.cmd)
         CMD_IO_WR: begin
            if (req.io_port == PORT_INDEX) begin
               index_in = req.write_data;
               armed_in = 1'b1;
            end else if (req.io_port == PORT_DATA) begin
               if (armed_ff) begin
                  armed_in = 1'b0;
                  if (slot_ok) begin
                     cfg_in[slot] = wr_val;
                     case (index_ff)
                        REG_NMI0:    nmi_vec_in[7:0]   = req.write_data;
                        REG_NMI1:    nmi_vec_in[15:8]  = req.write_data;
                        REG_NMI2:    nmi_vec_in[23:16] = req.write_data;
                        REG_NMI3:    nmi_vec_in[31:24] = req.write_data;
                        REG_NMI_CTL: nmi_en_in         = req.write_data[6];
                        default:     nmi_en_in         = nmi_en_ff;
                     endcase
                  end
               end
            end else if (req.io_port == PORT_EXTRA0) begin
               extra_in[0] = req.write_data & 8'h7E;
            end else if (req.io_port == PORT_EXTRA1) begin
               extra_in[1] = req.write_data;
            end else if (req.io_port == PORT_EXTRA2) begin
               extra_in[2] = req.write_data;
               // soft reset keeps the nmi vector itself
               if (cfg_ff[SLOT_CTL1][6] && req.write_data[3]) begin
                  srst      = 1'b1;
                  index_in  = 8'h00;
                  armed_in  = 1'b0;
                  nmi_en_in = 1'b0;
                  page_in   = '0;
                  for (int s = 0; s < CFG_DEPTH; s++) begin
                     cfg_in[s] = cfg_reset(4'(s));
                  end
                  for (int e = 0; e < EXTRA_DEPTH; e++) begin
                     extra_in[e] = 8'h00;
                  end
               end
            end else if (page_port) begin
               page_in[page_idx] = req.write_data;
            end
         end
         CMD_IO_RD: begin
            rd_data = 8'hFF;
            if (req.io_port == PORT_INDEX) begin
               rd_data = index_ff;
            end else if (req.io_port == PORT_DATA) begin
               if (armed_ff) begin
                  armed_in = 1'b0;
                  if (slot_ok) begin
                     rd_data = cfg_ff[slot];
                  end
               end
            end else if (req.io_port == PORT_EXTRA0) begin
               rd_data = extra_ff[0];
            end else if (req.io_port == PORT_EXTRA1) begin
               rd_data = extra_ff[1];
            end else if (req.io_port == PORT_EXTRA2) begin
               rd_data = extra_ff[2];
            end else if (page_port) begin
               rd_data = page_ff[page_idx];
            end
         end
         default: begin
            rd_data = 8'h00;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff   <= 8'h00;
         armed_ff   <= 1'b0;
         page_ff    <= '0;
         nmi_vec_ff <= 32'h0;
         nmi_en_ff  <= 1'b0;
         for (int s = 0; s < CFG_DEPTH; s++) begin
            cfg_ff[s] <= cfg_reset(4'(s));
         end
         for (int e = 0; e < EXTRA_DEPTH; e++) begin
            extra_ff[e] <= 8'h00;
         end
      end else if (go) begin
         index_ff   <= index_in;
         armed_ff   <= armed_in;
         page_ff    <= page_in;
         nmi_vec_ff <= nmi_vec_in;
         nmi_en_ff  <= nmi_en_in;
         cfg_ff     <= cfg_in;
         extra_ff   <= extra_in;
      end
   end

   assign rsp.read_data     = rd_data;
   assign rsp.nmi_vector    = nmi_vec_in;
   assign rsp.nmi_vector_on = nmi_en_in;
   assign rsp.soft_reset    = srst;
   assign win_base          = cfg_ff[SLOT_EMS_BASE][3:0];
   assign page_regs         = page_ff;

endmodule

// File: src/xcems_xlate.sv
// ems window match and physical address translation
module xcems_xlate
   import xcems_pkg::*;
#(
   parameter int NUM_PAGES = NUM_PAGES_DEF
) (
   input  req_type                   req,
   input  logic [3:0]                win_base,
   input  logic [NUM_PAGES-1:0][7:0] page_regs,
   input  logic [12:0]               mem_size_kb,
   output xl_rsp_type                rsp
);

   logic [6:0] win_blk [0:NUM_PAGES-1];
   logic [NUM_PAGES-1:0] page_hit;
   logic [6:0]  sel_page;
   logic [1:0]  sel_idx;
   logic        any_hit;
   logic [21:0] phys;
   logic [22:0] limit;

   always_comb begin
      for (int i = 0; i < NUM_PAGES; i++) begin
         win_blk[i] = WIN_BLOCK_BASE + {3'd0, win_base} + 7'(i);
         if (i == 1 || i == 2) begin
            win_blk[i] = win_blk[i] ^ WIN_BLOCK_FLIP;
         end
         page_hit[i] = page_regs[i][7] && ({1'b0, req.mem_addr[19:14]} == win_blk[i]);
      end
   end

   // lowest enabled page that matches wins
   always_comb begin
      any_hit  = 1'b0;
      sel_idx  = 2'd0;
      sel_page = 7'd0;
      for (int i = NUM_PAGES - 1; i >= 0; i--) begin
         if (page_hit[i]) begin
            any_hit  = 1'b1;
            sel_idx  = 2'(i);
            sel_page = page_regs[i][6:0];
         end
      end
   end

   assign phys  = {PHYS_BLOCK_BASE + {1'b0, sel_page}, req.mem_addr[13:0]};
   assign limit = {mem_size_kb, 10'd0};

   always_comb begin
      rsp = '0;
      if (req.cmd == CMD_XLATE && any_hit) begin
         rsp.ems_hit   = 1'b1;
         rsp.hit_page  = sel_idx;
         rsp.phys_addr = phys;
         rsp.in_range  = ({1'b0, phys} < limit);
      end
   end

endmodule
